@@ sv/epoch_to_calendar_macros.svh @@
// assertion macros shared by the checker of the epoch to calendar block
`ifndef EPOCH_TO_CALENDAR_MACROS_SVH
`define EPOCH_TO_CALENDAR_MACROS_SVH

// same-cycle implication, checked outside reset
`define E2C_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("epoch_to_calendar: assertion failed");

// next-cycle implication, checked outside reset
`define E2C_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("epoch_to_calendar: assertion failed");

`endif

@@ sv/e2c_pkg.sv @@
// constants, widths and tables of the epoch to calendar block
`timescale 1ns / 1ps
package e2c_pkg;

  localparam int NSTG       = 12;
  localparam int EPOCH_W    = 32;
  localparam int YEAR_W     = 12;
  localparam int MONTH_W    = 4;
  localparam int DAY_W      = 5;
  localparam int HOUR_W     = 5;
  localparam int MINUTE_W   = 6;
  localparam int SECOND_W   = 6;

  // 86400 = 675 << 7
  localparam int DAY_SHIFT  = 7;
  localparam int DAY_DIV    = 675;
  localparam int DN_W       = 16;
  localparam int SOD_W      = 17;
  localparam int HOUR_SECS  = 3600;
  localparam int HREM_W     = 12;
  localparam int MIN_SECS   = 60;

  localparam int DAYS_MAR0  = 719468;
  localparam int DAYS_ERA   = 146097;
  localparam int ERA4_BASE  = 4 * DAYS_ERA;
  localparam int ERA5_BASE  = 5 * DAYS_ERA;
  localparam int SHIFT_W    = 20;
  localparam int DIC_W      = 18;
  localparam int DAYS_4Y    = 1460;
  localparam int DAYS_100Y  = 36524;
  localparam int DAYS_YEAR  = 365;
  localparam int YIC_W      = 9;
  localparam int DIY_W      = 9;
  localparam int MI_W       = 4;
  localparam int MONTH_DIV  = 153;
  localparam int MX_W       = 11;

  localparam int YEAR_ERA4  = 1600;
  localparam int YEAR_ERA5  = 2000;

  // first day of each month within a march-based year
  function automatic logic [DIY_W-1:0] month_start(input logic [MI_W-1:0] mi);
    logic [DIY_W-1:0] s;
    case (mi)
      4'd0:    s = 9'd0;
      4'd1:    s = 9'd31;
      4'd2:    s = 9'd61;
      4'd3:    s = 9'd92;
      4'd4:    s = 9'd122;
      4'd5:    s = 9'd153;
      4'd6:    s = 9'd184;
      4'd7:    s = 9'd214;
      4'd8:    s = 9'd245;
      4'd9:    s = 9'd275;
      4'd10:   s = 9'd306;
      4'd11:   s = 9'd337;
      default: s = 9'd0;
    endcase
    return s;
  endfunction

endpackage

@@ sv/epoch_to_calendar.sv @@
// top level: unix seconds to civil date and time of day, pipelined
`timescale 1ns / 1ps
// Converts a 32-bit count of seconds since 1970-01-01 00:00:00 into year,
// month, day of month, hour, minute and second of the proleptic Gregorian
// calendar. The block is a 12-stage pipeline: it takes one timestamp every
// clock cycle while in_stall is low. Every division is by a constant and
// runs as a reciprocal multiply in one stage and a remainder in the next;
// the chain of day-count, four-year, year-in-era and month divisions sets
// the depth. A stalled output holds its result while bubbles further up
// still close, so in_stall rises only once every stage holds an item. An
// input of zero means no time is known and gives time_known low with all
// fields zero.
module epoch_to_calendar (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [e2c_pkg::EPOCH_W-1:0]    epoch_seconds,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           time_known,
  output logic [e2c_pkg::YEAR_W-1:0]     year,
  output logic [e2c_pkg::MONTH_W-1:0]    month,
  output logic [e2c_pkg::DAY_W-1:0]      day_of_month,
  output logic [e2c_pkg::HOUR_W-1:0]     hour,
  output logic [e2c_pkg::MINUTE_W-1:0]   minute,
  output logic [e2c_pkg::SECOND_W-1:0]   second
);
  import e2c_pkg::*;

  // stage control
  logic [NSTG:1]   vld;
  logic [NSTG+1:1] en;
  logic [NSTG:1]   vld_in;

  assign en[NSTG+1] = !out_stall;
  assign vld_in     = {vld[NSTG-1:1], in_valid};

  for (genvar k = 1; k <= NSTG; k++) begin : g_en
    assign en[k] = !vld[k] || en[k+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int k = 1; k <= NSTG; k++) begin
        if (en[k]) vld[k] <= vld_in[k];
      end
    end
  end

  assign in_stall  = !en[1];
  assign out_valid = vld[NSTG];

  // carried payload, indexed by the stage that holds it
  logic                 known_p [1:11];
  logic [DAY_SHIFT-1:0] tlo_p   [1:2];
  logic                 cyc5_p  [3:11];
  logic [DIC_W-1:0]     dic_p   [3:8];
  logic [2:0]           c36_p   [4:5];
  logic                 c146_p  [4:5];
  logic [HOUR_W-1:0]    hour_p  [5:11];
  logic [MINUTE_W-1:0]  min_p   [7:11];
  logic [SECOND_W-1:0]  sec_p   [7:11];
  logic [YIC_W-1:0]     yic_p   [9:11];
  logic [DIY_W-1:0]     diy_p   [9:11];
  logic [DIC_W-1:0]     num6;

  // divider outputs
  logic [DN_W-1:0]      dn2;
  logic [9:0]           drem2;
  logic [HOUR_W-1:0]    hour4;
  logic [HREM_W-1:0]    hrem4;
  logic [6:0]           q1460_5;
  logic [MINUTE_W-1:0]  min6;
  logic [SECOND_W-1:0]  sec6;
  logic [YIC_W-1:0]     yic8;
  logic [MI_W-1:0]      mi11;

  logic [SOD_W-1:0]     sod2;
  logic [SHIFT_W-1:0]   shifted;
  logic                 cyc5_next;
  logic [DIC_W-1:0]     dic_next;
  logic [2:0]           c36_next;
  logic [DIC_W-1:0]     num_next;
  logic [1:0]           c100;
  logic [DIC_W-1:0]     ybase;
  logic [DIC_W-1:0]     diy_next;
  logic [MX_W-1:0]      mx;

  // day number and second of day
  e2c_cdiv #(.XW(EPOCH_W - DAY_SHIFT), .DIV(DAY_DIV), .QW(DN_W), .RW(10)) u_day (
    .clk(clk), .en_a(en[1]), .en_b(en[2]),
    .x(epoch_seconds[EPOCH_W-1:DAY_SHIFT]), .q(dn2), .r(drem2)
  );

  assign sod2 = {drem2, tlo_p[2]};

  always_ff @(posedge clk) begin
    if (en[1]) begin
      known_p[1] <= (epoch_seconds != '0);
      tlo_p[1]   <= epoch_seconds[DAY_SHIFT-1:0];
    end
    if (en[2]) tlo_p[2] <= tlo_p[1];
    for (int k = 2; k <= 11; k++) begin
      if (en[k]) known_p[k] <= known_p[k-1];
    end
  end

  // time of day
  e2c_cdiv #(.XW(SOD_W), .DIV(HOUR_SECS), .QW(HOUR_W), .RW(HREM_W)) u_hour (
    .clk(clk), .en_a(en[3]), .en_b(en[4]), .x(sod2), .q(hour4), .r(hrem4)
  );

  e2c_cdiv #(.XW(HREM_W), .DIV(MIN_SECS), .QW(MINUTE_W), .RW(SECOND_W)) u_min (
    .clk(clk), .en_a(en[5]), .en_b(en[6]), .x(hrem4), .q(min6), .r(sec6)
  );

  always_ff @(posedge clk) begin
    if (en[5]) hour_p[5] <= hour4;
    for (int k = 6; k <= 11; k++) begin
      if (en[k]) hour_p[k] <= hour_p[k-1];
    end
    if (en[7]) begin
      min_p[7] <= min6;
      sec_p[7] <= sec6;
    end
    for (int k = 8; k <= 11; k++) begin
      if (en[k]) begin
        min_p[k] <= min_p[k-1];
        sec_p[k] <= sec_p[k-1];
      end
    end
  end

  // day in era: the era is always the fourth or fifth
  assign shifted   = SHIFT_W'(dn2) + SHIFT_W'(DAYS_MAR0);
  assign cyc5_next = (shifted >= SHIFT_W'(ERA5_BASE));
  assign dic_next  = DIC_W'(shifted - (cyc5_next ? SHIFT_W'(ERA5_BASE) : SHIFT_W'(ERA4_BASE)));

  assign c36_next = 3'(dic_p[3] >= DIC_W'(DAYS_100Y))
                  + 3'(dic_p[3] >= DIC_W'(2 * DAYS_100Y))
                  + 3'(dic_p[3] >= DIC_W'(3 * DAYS_100Y))
                  + 3'(dic_p[3] >= DIC_W'(4 * DAYS_100Y));

  always_ff @(posedge clk) begin
    if (en[3]) begin
      cyc5_p[3] <= cyc5_next;
      dic_p[3]  <= dic_next;
    end
    for (int k = 4; k <= 11; k++) begin
      if (en[k]) cyc5_p[k] <= cyc5_p[k-1];
    end
    for (int k = 4; k <= 8; k++) begin
      if (en[k]) dic_p[k] <= dic_p[k-1];
    end
    if (en[4]) begin
      c36_p[4]  <= c36_next;
      c146_p[4] <= (dic_p[3] == DIC_W'(DAYS_ERA - 1));
    end
    if (en[5]) begin
      c36_p[5]  <= c36_p[4];
      c146_p[5] <= c146_p[4];
    end
  end

  e2c_cdiv #(.XW(DIC_W), .DIV(DAYS_4Y), .QW(7), .RW(11)) u_d4y (
    .clk(clk), .en_a(en[4]), .en_b(en[5]), .x(dic_p[3]), .q(q1460_5), .r()
  );

  // year in era
  assign num_next = dic_p[5] - DIC_W'(q1460_5) + DIC_W'(c36_p[5]) - DIC_W'(c146_p[5]);

  always_ff @(posedge clk) begin
    if (en[6]) num6 <= num_next;
  end

  e2c_cdiv #(.XW(DIC_W), .DIV(DAYS_YEAR), .QW(YIC_W), .RW(9)) u_year (
    .clk(clk), .en_a(en[7]), .en_b(en[8]), .x(num6), .q(yic8), .r()
  );

  // day of the march-based year
  assign c100 = 2'(yic8 >= YIC_W'(100)) + 2'(yic8 >= YIC_W'(200))
              + 2'(yic8 >= YIC_W'(300));
  assign ybase = DIC_W'(yic8) * DIC_W'(DAYS_YEAR) + DIC_W'(yic8 >> 2) - DIC_W'(c100);
  assign diy_next = dic_p[8] - ybase;

  always_ff @(posedge clk) begin
    if (en[9]) begin
      yic_p[9] <= yic8;
      diy_p[9] <= diy_next[DIY_W-1:0];
    end
    for (int k = 10; k <= 11; k++) begin
      if (en[k]) begin
        yic_p[k] <= yic_p[k-1];
        diy_p[k] <= diy_p[k-1];
      end
    end
  end

  // month index, march = 0
  assign mx = MX_W'(diy_p[9]) * MX_W'(5) + MX_W'(2);

  e2c_cdiv #(.XW(MX_W), .DIV(MONTH_DIV), .QW(MI_W), .RW(8)) u_month (
    .clk(clk), .en_a(en[10]), .en_b(en[11]), .x(mx), .q(mi11), .r()
  );

  // output stage, all zero when no time is known
  logic [MONTH_W-1:0]  mon_next;
  logic [DIY_W-1:0]    dom_next;
  logic [YEAR_W-1:0]   yr_next;
  logic                jan_feb;

  assign jan_feb  = (mi11 >= MI_W'(10));
  assign mon_next = jan_feb ? MONTH_W'(mi11 - MI_W'(9)) : MONTH_W'(mi11 + MI_W'(3));
  assign dom_next = diy_p[11] - month_start(mi11) + DIY_W'(1);
  assign yr_next  = YEAR_W'(yic_p[11])
                  + (cyc5_p[11] ? YEAR_W'(YEAR_ERA5) : YEAR_W'(YEAR_ERA4))
                  + YEAR_W'(jan_feb);

  always_ff @(posedge clk) begin
    if (en[12]) begin
      time_known   <= known_p[11];
      year         <= known_p[11] ? yr_next : '0;
      month        <= known_p[11] ? mon_next : '0;
      day_of_month <= known_p[11] ? dom_next[DAY_W-1:0] : '0;
      hour         <= known_p[11] ? hour_p[11] : '0;
      minute       <= known_p[11] ? min_p[11] : '0;
      second       <= known_p[11] ? sec_p[11] : '0;
    end
  end

endmodule

@@ sv/e2c_cdiv.sv @@
// two-stage divider by a constant: reciprocal multiply, then remainder
`timescale 1ns / 1ps
module e2c_cdiv #(
  parameter int XW  = 18,
  parameter int DIV = 365,
  parameter int QW  = 9,
  parameter int RW  = 9
) (
  input  logic          clk,
  input  logic          en_a,
  input  logic          en_b,
  input  logic [XW-1:0] x,
  output logic [QW-1:0] q,
  output logic [RW-1:0] r
);

  // exact floor division for every x below 2**XW whose quotient fits in QW bits
  localparam int L  = $clog2(DIV);
  localparam int S  = XW + L;
  localparam int MW = XW + 1;
  localparam int PW = XW + MW;
  localparam logic [MW-1:0] M = MW'(((64'd1 << S) + 64'(DIV) - 64'd1) / DIV);

  logic [XW-1:0] x_a;
  logic [PW-1:0] prod;
  logic [PW-1:0] prod_next;
  logic [QW-1:0] qc;
  logic [XW-1:0] qd;
  logic [XW-1:0] rc;

  assign prod_next = PW'(x) * PW'(M);

  always_ff @(posedge clk) begin
    if (en_a) begin
      x_a  <= x;
      prod <= prod_next;
    end
  end

  assign qc = prod[S +: QW];
  assign qd = XW'(qc) * XW'(DIV);
  assign rc = x_a - qd;

  always_ff @(posedge clk) begin
    if (en_b) begin
      q <= qc;
      r <= rc[RW-1:0];
    end
  end

endmodule

@@ sv/e2c_checker.sv @@
// port-level checker of the epoch to calendar block, bound to the top level
`timescale 1ns / 1ps
`include "epoch_to_calendar_macros.svh"
module e2c_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  logic                           time_known,
  input  logic [e2c_pkg::YEAR_W-1:0]     year,
  input  logic [e2c_pkg::MONTH_W-1:0]    month,
  input  logic [e2c_pkg::DAY_W-1:0]      day_of_month,
  input  logic [e2c_pkg::HOUR_W-1:0]     hour,
  input  logic [e2c_pkg::MINUTE_W-1:0]   minute,
  input  logic [e2c_pkg::SECOND_W-1:0]   second
);
  import e2c_pkg::*;

  // a waiting result is not dropped
  `E2C_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)

  // pipeline comes out of reset empty
  `E2C_ASSERT_IMPL(a_reset_empty, $past(rst), !out_valid)

  // no-time results carry all-zero fields
  `E2C_ASSERT_IMPL(a_unknown_zero, out_valid && !time_known, (year == '0) && (month == '0) && (day_of_month == '0) && (hour == '0) && (minute == '0) && (second == '0))

  // known results carry in-range fields, with a year from 1970 on
  `E2C_ASSERT_IMPL(a_known_range, out_valid && time_known, (year >= YEAR_W'(1970)) && (month != '0) && (month <= MONTH_W'(12)) && (day_of_month != '0) && (hour < HOUR_W'(24)) && (minute < MINUTE_W'(60)) && (second < SECOND_W'(60)))

endmodule

bind epoch_to_calendar e2c_checker u_e2c_checker (.*);

@@ verif/testbench.sv @@
// self-checking testbench for the epoch to calendar pipeline
`timescale 1ns / 1ps
module testbench;
  import e2c_pkg::*;

  localparam int TOTAL_ITEMS  = 1300;
  localparam int QUIET_TAIL   = 150;
  localparam int HOLD_CYCLES  = 80;
  localparam int HOLD_EVERY   = 400;
  localparam int HOLD_COUNT   = 2;
  localparam int DRAIN_CYCLES = 40;
  localparam int IDLE_LIMIT   = 2000;
  localparam int MAX_REPORTS  = 10;

  localparam int unsigned SECS_DAY   = 86400;
  localparam int unsigned MAR1_BIAS  = 719468;
  localparam int unsigned ERA_DAYS   = 146097;
  localparam int unsigned QUAD_DAYS  = 1460;
  localparam int unsigned CENT_DAYS  = 36524;
  localparam int unsigned YEAR_DAYS  = 365;
  localparam int unsigned FIVE_MONTH = 153;

  typedef struct packed {
    logic                known;
    logic [YEAR_W-1:0]   year;
    logic [MONTH_W-1:0]  month;
    logic [DAY_W-1:0]    day;
    logic [HOUR_W-1:0]   hour;
    logic [MINUTE_W-1:0] minute;
    logic [SECOND_W-1:0] second;
  } civil_t;

  typedef struct {
    logic [EPOCH_W-1:0] epoch;
    civil_t             civil;
  } due_t;

  logic clk;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [EPOCH_W-1:0] epoch_seconds = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic time_known;
  logic [YEAR_W-1:0] year;
  logic [MONTH_W-1:0] month;
  logic [DAY_W-1:0] day_of_month;
  logic [HOUR_W-1:0] hour;
  logic [MINUTE_W-1:0] minute;
  logic [SECOND_W-1:0] second;

  logic [EPOCH_W-1:0] epoch_backlog[$];
  due_t calendar_due[$];
  int total_items = 0;
  int items_accepted = 0;
  int results_seen = 0;
  int errors = 0;

  epoch_to_calendar dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .epoch_seconds(epoch_seconds),
    .out_valid(out_valid), .out_stall(out_stall),
    .time_known(time_known), .year(year), .month(month),
    .day_of_month(day_of_month), .hour(hour), .minute(minute), .second(second)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // march-based year split into 400-year eras
  function automatic civil_t civil_from_epoch(input logic [EPOCH_W-1:0] secs);
    civil_t c;
    int unsigned s, days, tod, shifted, era, doe, yoe, doy, mp, mon;
    c = '0;
    s = secs;
    if (s != 0) begin
      days = s / SECS_DAY;
      tod = s % SECS_DAY;
      shifted = days + MAR1_BIAS;
      era = shifted / ERA_DAYS;
      doe = shifted - era * ERA_DAYS;
      yoe = (doe - doe / QUAD_DAYS + doe / CENT_DAYS - doe / (ERA_DAYS - 1)) / YEAR_DAYS;
      doy = doe - (YEAR_DAYS * yoe + yoe / 4 - yoe / 100);
      mp = (5 * doy + 2) / FIVE_MONTH;
      mon = (mp < 10) ? mp + 3 : mp - 9;
      c.known = 1'b1;
      c.day = DAY_W'(doy - (FIVE_MONTH * mp + 2) / 5 + 1);
      c.month = MONTH_W'(mon);
      c.year = YEAR_W'(yoe + era * 400 + ((mon <= 2) ? 1 : 0));
      c.hour = HOUR_W'(tod / 3600);
      c.minute = MINUTE_W'((tod % 3600) / 60);
      c.second = SECOND_W'(tod % 60);
    end
    return c;
  endfunction

  function automatic logic [EPOCH_W-1:0] random_epoch();
    logic [EPOCH_W-1:0] v;
    longint unsigned wide;
    int unsigned pick;
    pick = $urandom_range(0, 49);
    if (pick == 0) begin
      v = '0;
    end else if (pick < 20) begin
      v = $urandom;
    end else if (pick < 34) begin
      // land on or next to a midnight, or at a random time of that day
      wide = longint'($urandom_range(0, 49710)) * SECS_DAY;
      case ($urandom_range(0, 3))
        0: wide = wide + 0;
        1: wide = wide + 1;
        2: wide = wide + SECS_DAY - 1;
        default: wide = wide + $urandom_range(0, SECS_DAY - 1);
      endcase
      v = wide[EPOCH_W-1:0];
    end else if (pick < 39) begin
      v = $urandom_range(0, 200000);
    end else if (pick < 44) begin
      v = 32'hFFFF_FFFF - $urandom_range(0, 200000);
    end else begin
      v = 32'h1 << $urandom_range(0, EPOCH_W - 1);
      if ($urandom_range(0, 1) == 1) v = ~v;
    end
    return v;
  endfunction

  initial begin
    logic [EPOCH_W-1:0] directed[$];
    directed = '{
      32'd0, 32'd1, 32'd59, 32'd60, 32'd3599, 32'd3600, 32'd86399, 32'd86400,
      32'd2678400,               // first of february 1970
      32'd68169600,              // leap day 1972
      32'd946684799, 32'd946684800,
      32'd951782400,             // leap day 2000, last day of an era
      32'd951868800,             // first day of a new era
      32'd978307199, 32'd1234567890, 32'd2147483647, 32'd2147483648,
      32'd4102444800,
      32'd4107542399, 32'd4107542400,  // 2100 is not a leap year
      32'd4294944000, 32'd4294967295,
      32'hAAAA_AAAA, 32'h5555_5555
    };
    foreach (directed[i]) epoch_backlog.push_back(directed[i]);
    while (epoch_backlog.size() < TOTAL_ITEMS) epoch_backlog.push_back(random_epoch());
    total_items = epoch_backlog.size();

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    do @(posedge clk);
    while (items_accepted != total_items || calendar_due.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // source side: offers backlog items, holds them while stalled
  logic src_calm = 1'b0;
  int src_gap = 0;

  always @(posedge clk) begin : source
    logic took, nxt_valid;
    logic [EPOCH_W-1:0] nxt_epoch;
    due_t d;
    took = in_valid && !in_stall;
    nxt_valid = in_valid && !took;
    nxt_epoch = epoch_seconds;
    if (rst) begin
      nxt_valid = 1'b0;
    end else begin
      if (took) begin
        d.epoch = epoch_seconds;
        d.civil = civil_from_epoch(epoch_seconds);
        calendar_due.push_back(d);
        items_accepted++;
      end
      if ($urandom_range(0, 99) == 0) src_calm = !src_calm;
      if (!nxt_valid) begin
        if (src_gap > 0) begin
          src_gap--;
        end else if (epoch_backlog.size() != 0) begin
          if (!src_calm && epoch_backlog.size() > QUIET_TAIL && $urandom_range(0, 5) == 0) begin
            src_gap = $urandom_range(0, 10);
          end else begin
            nxt_valid = 1'b1;
            nxt_epoch = epoch_backlog.pop_front();
          end
        end
      end
    end
    in_valid <= nxt_valid;
    epoch_seconds <= nxt_epoch;
  end

  // sink side: checks each transfer against the oldest expected calendar
  logic sink_calm = 1'b0;
  int sink_gap = 0;
  int hold_left = 0;
  int holds_done = 0;

  always @(posedge clk) begin : sink
    logic nxt_stall;
    civil_t got;
    due_t head;
    nxt_stall = 1'b0;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        got = {time_known, year, month, day_of_month, hour, minute, second};
        if (calendar_due.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("unexpected transfer: known=%0d %0d-%0d-%0d %0d:%0d:%0d",
                     got.known, got.year, got.month, got.day,
                     got.hour, got.minute, got.second);
        end else begin
          head = calendar_due.pop_front();
          if (got.known != head.civil.known || got.year != head.civil.year ||
              got.month != head.civil.month || got.day != head.civil.day ||
              got.hour != head.civil.hour || got.minute != head.civil.minute ||
              got.second != head.civil.second) begin
            errors++;
            if (errors <= MAX_REPORTS)
              $display("epoch %0d: expected known=%0d %0d-%0d-%0d %0d:%0d:%0d, got known=%0d %0d-%0d-%0d %0d:%0d:%0d",
                       head.epoch, head.civil.known, head.civil.year, head.civil.month,
                       head.civil.day, head.civil.hour, head.civil.minute,
                       head.civil.second, got.known, got.year, got.month, got.day,
                       got.hour, got.minute, got.second);
          end
        end
        results_seen++;
      end
      // long hold-off lets the pipeline fill and push back on the source
      if (hold_left == 0 && holds_done < HOLD_COUNT &&
          results_seen >= (holds_done + 1) * HOLD_EVERY) begin
        hold_left = HOLD_CYCLES;
        holds_done++;
      end
      if ($urandom_range(0, 99) == 0) sink_calm = !sink_calm;
      if (hold_left > 0) begin
        hold_left--;
        nxt_stall = 1'b1;
      end else if (sink_gap > 0) begin
        sink_gap--;
        nxt_stall = 1'b1;
      end else if (!sink_calm && results_seen + QUIET_TAIL < total_items &&
                   $urandom_range(0, 7) == 0) begin
        sink_gap = $urandom_range(0, 10);
        nxt_stall = 1'b1;
      end
    end
    out_stall <= nxt_stall;
  end

  // watchdog: too long without any transfer on either side
  int idle_cycles = 0;

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
